[hw/rtl/rfft_pkg.sv]
// ----------------------------------------------------------------------------
// rfft_pkg
// Shared types, codes and constants for the radix-2 FFT block.
// ----------------------------------------------------------------------------
package rfft_pkg;

  // item action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result kind codes
  localparam logic RK_DONE = 1'b0;
  localparam logic RK_BIN  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2    = 2'd1;

  localparam int         L_W        = 4;
  localparam logic [3:0] LOG2_RESET = 4'd10;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDOUT,
    ST_REV_RD,
    ST_REV_WA,
    ST_REV_WB,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB,
    ST_SC_RD,
    ST_SC_WR,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    WS_NONE,
    WS_SAMPLE,
    WS_RDA,
    WS_RDB,
    WS_SUM,
    WS_DIFF,
    WS_SCALE
  } wsrc_t;

  typedef enum logic [1:0] {
    OL_NONE,
    OL_BIN,
    OL_DONE
  } out_ld_t;

  typedef struct packed {
    wsrc_t   wsrc;
    logic    rd_en;
    logic    mul_en;
    logic    sum_en;
    out_ld_t out_ld;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) return 32'sh7fffffff;
    if (x < -36'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

[hw/rtl/rfft_in_if.sv]
// ----------------------------------------------------------------------------
// rfft_in_if
// Input item channel: action, point index and complex sample.
// ----------------------------------------------------------------------------
interface rfft_in_if #(
  parameter int IW = 10,
  parameter int SW = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [IW-1:0]        point_index;
  logic signed [SW-1:0] sample_re;
  logic signed [SW-1:0] sample_im;

  modport source (output valid, action, point_index, sample_re, sample_im, input ready);
  modport sink (input valid, action, point_index, sample_re, sample_im, output ready);
endinterface

[hw/rtl/rfft_out_if.sv]
// ----------------------------------------------------------------------------
// rfft_out_if
// Result item channel: result kind and complex bin.
// ----------------------------------------------------------------------------
interface rfft_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [31:0] bin_re;
  logic signed [31:0] bin_im;

  modport source (output valid, result_kind, bin_re, bin_im, input ready);
  modport sink (input valid, result_kind, bin_re, bin_im, output ready);
endinterface

[hw/rtl/rfft_ctrl.sv]
// ----------------------------------------------------------------------------
// rfft_ctrl
// Sequencer: config registers, handshake, bit-reversal, butterfly and
// scaling loops; drives datapath commands and addresses.
// ----------------------------------------------------------------------------
module rfft_ctrl #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rfft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfft_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic [$clog2(MAX_POINTS)-1:0]       in_point_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rfft_pkg::dp_cmd_t                   cmd,
  output logic [$clog2(MAX_POINTS)-1:0]       addr_a,
  output logic [$clog2(MAX_POINTS)-1:0]       addr_b,
  output logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
  output logic [$clog2(MAX_POINTS)-2:0]       tw_m,
  output logic                                inverse,
  output logic [rfft_pkg::L_W-1:0]            act_l
);
  import rfft_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW - 1;

  ctrl_state_t    state_r, state_nxt;
  logic           inv_r;
  logic [L_W-1:0] log2_r;
  logic [AW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [L_W-1:0] st_r, st_nxt;
  logic           out_vld_r, out_vld_nxt;

  logic [AW-1:0] mask, idx, rev_full, rev_j, a_addr, b_addr, half;
  logic [CW-1:0] lo;
  logic          accept;

  always_comb begin
    if (log2_r == '0) act_l = L_W'(1);
    else if (log2_r > L_W'(AW)) act_l = L_W'(AW);
    else act_l = log2_r;
    mask = ~({AW{1'b1}} << act_l);
    idx  = in_point_index & mask;
    for (int k = 0; k < AW; k++) rev_full[k] = i_r[AW-1-k];
    rev_j  = rev_full >> (L_W'(AW) - act_l);
    lo     = ~({CW{1'b1}} << (st_r - L_W'(1)));
    half   = AW'(1) << (st_r - L_W'(1));
    a_addr = {cnt_r & ~lo, 1'b0} | {1'b0, cnt_r & lo};
    b_addr = a_addr | half;
    tw_m   = (cnt_r & lo) << (L_W'(AW) - st_r);
  end

  assign inverse   = inv_r;
  assign in_ready  = (state_r == ST_IDLE) && (!out_vld_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_vld_r;

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_action == ACT_RUN) begin
          state_nxt = ST_REV_RD;
          i_nxt     = '0;
        end else if (accept && in_action == ACT_READ) begin
          state_nxt = ST_RDOUT;
        end
      end
      ST_RDOUT: state_nxt = ST_IDLE;
      ST_REV_RD: begin
        if (i_r < rev_j) begin
          state_nxt = ST_REV_WA;
        end else if (i_r == mask) begin
          state_nxt = ST_BF_RD;
          st_nxt    = L_W'(1);
          cnt_nxt   = '0;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      ST_REV_WA: state_nxt = ST_REV_WB;
      ST_REV_WB: begin
        if (i_r == mask) begin
          state_nxt = ST_BF_RD;
          st_nxt    = L_W'(1);
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_REV_RD;
          i_nxt     = i_r + AW'(1);
        end
      end
      ST_BF_RD:  state_nxt = ST_BF_MUL;
      ST_BF_MUL: state_nxt = ST_BF_SUM;
      ST_BF_SUM: state_nxt = ST_BF_WA;
      ST_BF_WA:  state_nxt = ST_BF_WB;
      ST_BF_WB: begin
        if (cnt_r == mask[AW-1:1]) begin
          if (st_r == act_l) begin
            state_nxt = inv_r ? ST_SC_RD : ST_DONE;
            i_nxt     = '0;
          end else begin
            state_nxt = ST_BF_RD;
            st_nxt    = st_r + L_W'(1);
            cnt_nxt   = '0;
          end
        end else begin
          state_nxt = ST_BF_RD;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      ST_SC_RD: state_nxt = ST_SC_WR;
      ST_SC_WR: begin
        if (i_r == mask) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SC_RD;
          i_nxt     = i_r + AW'(1);
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd     = '{wsrc: WS_NONE, rd_en: 1'b0, mul_en: 1'b0, sum_en: 1'b0, out_ld: OL_NONE};
    addr_a  = i_r;
    addr_b  = rev_j;
    wr_addr = i_r;
    case (state_r)
      ST_IDLE: begin
        addr_a  = idx;
        wr_addr = idx;
        if (accept && in_action == ACT_WRITE) cmd.wsrc = WS_SAMPLE;
        if (accept && in_action == ACT_READ) cmd.rd_en = 1'b1;
      end
      ST_RDOUT:  cmd.out_ld = OL_BIN;
      ST_REV_RD: cmd.rd_en = (i_r < rev_j);
      ST_REV_WA: cmd.wsrc = WS_RDB;
      ST_REV_WB: begin
        wr_addr  = rev_j;
        cmd.wsrc = WS_RDA;
      end
      ST_BF_RD: begin
        addr_a    = a_addr;
        addr_b    = b_addr;
        cmd.rd_en = 1'b1;
      end
      ST_BF_MUL: cmd.mul_en = 1'b1;
      ST_BF_SUM: cmd.sum_en = 1'b1;
      ST_BF_WA: begin
        wr_addr  = a_addr;
        cmd.wsrc = WS_SUM;
      end
      ST_BF_WB: begin
        wr_addr  = b_addr;
        cmd.wsrc = WS_DIFF;
      end
      ST_SC_RD: cmd.rd_en = 1'b1;
      ST_SC_WR: cmd.wsrc = WS_SCALE;
      ST_DONE:  cmd.out_ld = OL_DONE;
      default:  cmd.wsrc = WS_NONE;
    endcase
  end

  always_comb begin
    if (cmd.out_ld != OL_NONE) out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
    else out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      inv_r     <= 1'b0;
      log2_r    <= LOG2_RESET;
      i_r       <= '0;
      cnt_r     <= '0;
      st_r      <= L_W'(1);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      cnt_r     <= cnt_nxt;
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we && cfg_index == CFG_INVERSE) inv_r <= cfg_wdata[0];
      if (cfg_we && cfg_index == CFG_LOG2) log2_r <= cfg_wdata;
    end
  end

endmodule

[hw/rtl/rfft_dp.sv]
// ----------------------------------------------------------------------------
// rfft_dp
// Datapath: point stores, twiddle ROM, butterfly multiply and add,
// inverse scaling and the result register.
// ----------------------------------------------------------------------------
module rfft_dp #(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  rfft_pkg::dp_cmd_t                 cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]     addr_a,
  input  logic [$clog2(MAX_POINTS)-1:0]     addr_b,
  input  logic [$clog2(MAX_POINTS)-1:0]     wr_addr,
  input  logic [$clog2(MAX_POINTS)-2:0]     tw_m,
  input  logic                              inverse,
  input  logic [rfft_pkg::L_W-1:0]          act_l,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_im,
  output logic                              out_kind,
  output logic signed [31:0]                out_re,
  output logic signed [31:0]                out_im
);
  import rfft_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int RW = AW - 1;
  localparam int Q  = MAX_POINTS / 4;

  logic signed [31:0] mem_re [MAX_POINTS];
  logic signed [31:0] mem_im [MAX_POINTS];
  logic [14:0]        rom [0:Q];

  // Q15 sine of 2*pi*g/MAX_POINTS by an integer Taylor series
  for (genvar g = 0; g <= Q; g++) begin : g_rom
    localparam longint unsigned TH  = (PI_Q30 * 64'd2 * 64'(g)) >> AW;
    localparam longint unsigned X2  = (TH * TH) >> 30;
    localparam longint unsigned T1  = ((TH * X2) >> 30) / 64'd6;
    localparam longint unsigned T2  = ((T1 * X2) >> 30) / 64'd20;
    localparam longint unsigned T3  = ((T2 * X2) >> 30) / 64'd42;
    localparam longint unsigned T4  = ((T3 * X2) >> 30) / 64'd72;
    localparam longint unsigned T5  = ((T4 * X2) >> 30) / 64'd110;
    localparam longint unsigned T6  = ((T5 * X2) >> 30) / 64'd156;
    localparam longint unsigned T7  = ((T6 * X2) >> 30) / 64'd210;
    localparam longint unsigned T8  = ((T7 * X2) >> 30) / 64'd272;
    localparam longint unsigned T9  = ((T8 * X2) >> 30) / 64'd342;
    localparam longint unsigned T10 = ((T9 * X2) >> 30) / 64'd420;
    localparam longint unsigned T11 = ((T10 * X2) >> 30) / 64'd506;
    localparam longint unsigned T12 = ((T11 * X2) >> 30) / 64'd600;
    localparam longint S = longint'(TH) - longint'(T1) + longint'(T2) - longint'(T3)
                         + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                         + longint'(T8) - longint'(T9) + longint'(T10) - longint'(T11)
                         + longint'(T12);
    localparam longint SP = (S < 64'sd0) ? 64'sd0 : S;
    localparam longint V  = (SP + 64'sd16384) >>> 15;
    assign rom[g] = (V > 64'sd32767) ? 15'h7fff : V[14:0];
  end

  logic signed [31:0] ra_re_r, ra_im_r, rb_re_r, rb_im_r;
  logic [14:0]        cos_r, sin_r;
  logic               neg_r;
  logic signed [48:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [34:0] tr_r, ti_r;
  logic               out_kind_r;
  logic signed [31:0] out_re_r, out_im_r;

  logic [AW-1:0]      mm, c_addr, s_addr;
  logic               neg;
  logic signed [16:0] wr, wi, c17, s17;
  logic signed [49:0] t_re, t_im;
  logic signed [32:0] sc_re, sc_im, rnd;
  logic signed [31:0] wd_re, wd_im;

  // quadrant fold of the twiddle index
  always_comb begin
    mm = AW'(tw_m);
    if (mm <= AW'(Q)) begin
      c_addr = AW'(Q) - mm;
      s_addr = mm;
      neg    = 1'b0;
    end else begin
      c_addr = mm - AW'(Q);
      s_addr = AW'(2 * Q) - mm;
      neg    = 1'b1;
    end
  end

  always_comb begin
    c17  = {2'b00, cos_r};
    s17  = {2'b00, sin_r};
    wr   = neg_r ? -c17 : c17;
    wi   = inverse ? s17 : -s17;
    t_re = 50'(p_rr_r) - 50'(p_ii_r) + 50'sd16384;
    t_im = 50'(p_ri_r) + 50'(p_ir_r) + 50'sd16384;
    rnd   = 33'sd1 <<< (act_l - L_W'(1));
    sc_re = (33'(ra_re_r) + rnd) >>> act_l;
    sc_im = (33'(ra_im_r) + rnd) >>> act_l;
  end

  always_comb begin
    case (cmd.wsrc)
      WS_SAMPLE: begin
        wd_re = 32'(sample_re);
        wd_im = 32'(sample_im);
      end
      WS_RDA: begin
        wd_re = ra_re_r;
        wd_im = ra_im_r;
      end
      WS_RDB: begin
        wd_re = rb_re_r;
        wd_im = rb_im_r;
      end
      WS_SUM: begin
        wd_re = sat32(36'(ra_re_r) + 36'(tr_r));
        wd_im = sat32(36'(ra_im_r) + 36'(ti_r));
      end
      WS_DIFF: begin
        wd_re = sat32(36'(ra_re_r) - 36'(tr_r));
        wd_im = sat32(36'(ra_im_r) - 36'(ti_r));
      end
      WS_SCALE: begin
        wd_re = sc_re[31:0];
        wd_im = sc_im[31:0];
      end
      default: begin
        wd_re = ra_re_r;
        wd_im = ra_im_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wsrc != WS_NONE) begin
      mem_re[wr_addr] <= wd_re;
      mem_im[wr_addr] <= wd_im;
    end
    if (cmd.rd_en) begin
      ra_re_r <= mem_re[addr_a];
      ra_im_r <= mem_im[addr_a];
      rb_re_r <= mem_re[addr_b];
      rb_im_r <= mem_im[addr_b];
      cos_r   <= rom[c_addr[RW-1:0]];
      sin_r   <= rom[s_addr[RW-1:0]];
      neg_r   <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_rr_r <= rb_re_r * wr;
      p_ii_r <= rb_im_r * wi;
      p_ri_r <= rb_re_r * wi;
      p_ir_r <= rb_im_r * wr;
    end
    if (cmd.sum_en) begin
      tr_r <= t_re[49:15];
      ti_r <= t_im[49:15];
    end
    case (cmd.out_ld)
      OL_BIN: begin
        out_kind_r <= RK_BIN;
        out_re_r   <= ra_re_r;
        out_im_r   <= ra_im_r;
      end
      OL_DONE: begin
        out_kind_r <= RK_DONE;
        out_re_r   <= '0;
        out_im_r   <= '0;
      end
      default: out_kind_r <= out_kind_r;
    endcase
  end

  assign out_kind = out_kind_r;
  assign out_re   = out_re_r;
  assign out_im   = out_im_r;

endmodule

[hw/rtl/radix2_complex_fft.sv]
// Sample write: one item per cycle when idle and no result is held. Bin read:
// the bin is registered, then loaded into the result register. Run: bit
// reversal swaps each out-of-order pair, then (n/2)*log2(n) butterflies each
// read, multiply, sum and write a and b; inverse then scales each point. One
// finish item follows. Reset (synchronous, rst_n low) clears control and
// inverse, sets log2 to 10; stores are not cleared, undefined until written.
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 decimation-in-time complex FFT, forward or inverse.
// ----------------------------------------------------------------------------
module radix2_complex_fft #(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rfft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfft_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rfft_in_if.sink                          in_ch,
  rfft_out_if.source                       out_ch
);
  import rfft_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  dp_cmd_t        cmd;
  logic [AW-1:0]  addr_a, addr_b, wr_addr;
  logic [AW-2:0]  tw_m;
  logic           inverse;
  logic [L_W-1:0] act_l;

  rfft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_action      (in_ch.action),
    .in_point_index (in_ch.point_index),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cmd            (cmd),
    .addr_a         (addr_a),
    .addr_b         (addr_b),
    .wr_addr        (wr_addr),
    .tw_m           (tw_m),
    .inverse        (inverse),
    .act_l          (act_l)
  );

  rfft_dp #(.MAX_POINTS(MAX_POINTS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .wr_addr   (wr_addr),
    .tw_m      (tw_m),
    .inverse   (inverse),
    .act_l     (act_l),
    .sample_re (in_ch.sample_re),
    .sample_im (in_ch.sample_im),
    .out_kind  (out_ch.result_kind),
    .out_re    (out_ch.bin_re),
    .out_im    (out_ch.bin_im)
  );

`ifndef SYNTHESIS
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.action == ACT_RUN |=> !in_ch.ready)
    else $error("input taken during a run");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.action == ACT_READ |=> ##1 out_ch.valid)
    else $error("read item gave no result");

  a_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_kind == RK_DONE |-> out_ch.bin_re == 0 && out_ch.bin_im == 0)
    else $error("finish item carries bin data");
`endif

endmodule

[tb/radix2_complex_fft_test.sv]
// ----------------------------------------------------------------------------
// radix2_complex_fft_test
// Self-checking bench for the radix-2 FFT block: fills the point store, runs
// forward and inverse transforms over many sizes, reads bins back and checks
// every result item against a bit-exact fixed-point FFT kept in the bench.
// ----------------------------------------------------------------------------
module radix2_complex_fft_test;
  import rfft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NPTS       = 1024;
  localparam int         LOG2_MAX   = 10;
  localparam int         MAX_CYCLES = 3000000;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  typedef struct {
    logic [1:0]         act;
    logic [9:0]         idx;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } fft_req_t;

  typedef struct {
    logic               kind;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } fft_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rfft_in_if  in_ch ();
  rfft_out_if out_ch ();

  radix2_complex_fft uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  fft_req_t pending_items[$];
  fft_rsp_t expected_bins[$];
  int       errors = 0;
  int       cycles = 0;

  // bench-side copy of the block
  logic signed [31:0] mem_re[NPTS];
  logic signed [31:0] mem_im[NPTS];
  int                 sine_q15[NPTS/4+1];
  logic               mode_inv;
  logic [3:0]         mode_log2;

  // generation-side bookkeeping
  bit written[NPTS];
  int gen_n;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int rom_entry(int j);
    longint unsigned th, x2, term;
    longint          acc, v;
    th   = (64'd3373259426 * 64'd2 * longint'(j)) / NPTS;
    x2   = (th * th) >> 30;
    term = th;
    acc  = longint'(th);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    v = (acc + 16384) >>> 15;
    return (v > 32767) ? 32767 : int'(v);
  endfunction

  function automatic int eff_log2(logic [3:0] l);
    if (l < 1) return 1;
    if (l > LOG2_MAX) return LOG2_MAX;
    return int'(l);
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  task automatic transform_store();
    int  lg, n, j, half, sh;
    longint wr, ws, wi, br, bi, ar, ai, tr, ti, rnd;
    logic signed [31:0] t;
    lg = eff_log2(mode_log2);
    n  = 1 << lg;
    for (int i = 0; i < n; i++) begin
      j = 0;
      for (int b = 0; b < lg; b++) j |= ((i >> b) & 1) << (lg - 1 - b);
      if (i < j) begin
        t = mem_re[i]; mem_re[i] = mem_re[j]; mem_re[j] = t;
        t = mem_im[i]; mem_im[i] = mem_im[j]; mem_im[j] = t;
      end
    end
    for (int st = 1; st <= lg; st++) begin
      half = 1 << (st - 1);
      sh   = LOG2_MAX - st;
      for (int base = 0; base < n; base += 2 * half) begin
        for (int k = 0; k < half; k++) begin
          int m, a, bb;
          m = k << sh;
          if (m <= NPTS / 4) begin
            wr = sine_q15[NPTS/4 - m];
            ws = sine_q15[m];
          end else begin
            wr = -longint'(sine_q15[m - NPTS/4]);
            ws = sine_q15[NPTS/2 - m];
          end
          wi = mode_inv ? ws : -ws;
          a  = base + k;
          bb = a + half;
          br = mem_re[bb]; bi = mem_im[bb];
          ar = mem_re[a];  ai = mem_im[a];
          tr = (br * wr - bi * wi + 16384) >>> 15;
          ti = (br * wi + bi * wr + 16384) >>> 15;
          mem_re[bb] = clip32(ar - tr);
          mem_im[bb] = clip32(ai - ti);
          mem_re[a]  = clip32(ar + tr);
          mem_im[a]  = clip32(ai + ti);
        end
      end
    end
    if (mode_inv) begin
      rnd = longint'(1) << (lg - 1);
      for (int i = 0; i < n; i++) begin
        mem_re[i] = 32'(((longint'(mem_re[i]) + rnd) >>> lg));
        mem_im[i] = 32'(((longint'(mem_im[i]) + rnd) >>> lg));
      end
    end
  endtask

  task automatic predict_item(fft_req_t it);
    int       ix;
    fft_rsp_t r;
    ix = it.idx & ((1 << eff_log2(mode_log2)) - 1);
    case (it.act)
      ACT_WRITE: begin
        mem_re[ix] = it.re;
        mem_im[ix] = it.im;
      end
      ACT_RUN: begin
        transform_store();
        r.kind = RK_DONE; r.re = 0; r.im = 0;
        expected_bins.push_back(r);
      end
      ACT_READ: begin
        r.kind = RK_BIN; r.re = mem_re[ix]; r.im = mem_im[ix];
        expected_bins.push_back(r);
      end
      default: ;
    endcase
  endtask

  // monitor, predictor update and watchdog
  always @(posedge clk) begin
    fft_rsp_t e;
    fft_req_t q;
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_INVERSE) mode_inv = cfg_wdata[0];
        else if (cfg_index == CFG_LOG2) mode_log2 = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bins.size() == 0) begin
          $error("unexpected result item: kind %0d", out_ch.result_kind);
          errors++;
        end else begin
          e = expected_bins.pop_front();
          if (out_ch.result_kind !== e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, out_ch.result_kind);
            errors++;
          end
          if (out_ch.bin_re !== e.re) begin
            $error("bin_re: expected %0d, got %0d", e.re, out_ch.bin_re);
            errors++;
          end
          if (out_ch.bin_im !== e.im) begin
            $error("bin_im: expected %0d, got %0d", e.im, out_ch.bin_im);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        q.act = in_ch.action; q.idx = in_ch.point_index;
        q.re = in_ch.sample_re; q.im = in_ch.sample_im;
        predict_item(q);
      end
    end
  end

  // item driver
  logic in_took, out_took;
  int   in_gap, out_stall;
  bit   in_burst, out_burst;

  always @(posedge clk) begin
    in_took  <= in_ch.valid && in_ch.ready;
    out_took <= out_ch.valid && out_ch.ready;
  end

  function automatic int draw_wait(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 19);
  endfunction

  always @(negedge clk) begin
    fft_req_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_took) begin
      // hold until accepted
    end else if (in_gap > 0) begin
      in_gap--;
      in_ch.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      it = pending_items.pop_front();
      in_ch.valid       <= 1'b1;
      in_ch.action      <= it.act;
      in_ch.point_index <= it.idx;
      in_ch.sample_re   <= it.re;
      in_ch.sample_im   <= it.im;
      if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
      in_gap = draw_wait(in_burst);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 31) == 0) out_burst = ~out_burst;
      out_stall = draw_wait(out_burst);
    end else if (out_stall > 0 && !out_ch.ready) begin
      out_stall--;
    end
    out_ch.ready <= rst_n && (out_stall == 0) && !out_took;
  end

  // stimulus helpers
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(logic [1:0] act, int ix, logic signed [15:0] re,
                           logic signed [15:0] im);
    fft_req_t it;
    it.act = act; it.idx = ix[9:0]; it.re = re; it.im = im;
    if (act == ACT_WRITE) written[ix & (gen_n - 1)] = 1;
    pending_items.push_back(it);
  endtask

  // upper index bits are don't-care, so randomize them
  function automatic int alias_idx(int ix);
    return (($urandom & 10'h3ff) & ~(gen_n - 1)) | ix;
  endfunction

  task automatic fill_missing();
    for (int i = 0; i < gen_n; i++)
      if (!written[i]) push_item(ACT_WRITE, alias_idx(i), rand_sample(), rand_sample());
  endtask

  task automatic read_some(int cnt);
    for (int i = 0; i < cnt; i++) begin
      int ix;
      ix = $urandom_range(0, gen_n - 1);
      if (written[ix]) push_item(ACT_READ, alias_idx(ix), 0, 0);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] ix, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= ix; cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_bins.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_traffic(int budget);
    int start, k;
    start = pending_items.size();
    while (pending_items.size() - start < budget) begin
      if ($urandom_range(0, 99) < 70) begin
        k = $urandom_range(1, gen_n);
        for (int i = 0; i < k; i++)
          push_item(ACT_WRITE, $urandom & 10'h3ff, rand_sample(), rand_sample());
        fill_missing();
        repeat ($urandom_range(1, 3)) push_item(ACT_RUN, $urandom & 10'h3ff, 16'($urandom),
                                               16'($urandom));
        read_some($urandom_range(1, gen_n + 2));
      end else begin
        case ($urandom_range(0, 2))
          0: push_item(ACT_NOP, $urandom & 10'h3ff, 16'($urandom), 16'($urandom));
          1: read_some(1);
          default: push_item(ACT_WRITE, $urandom & 10'h3ff, rand_sample(), rand_sample());
        endcase
      end
    end
  endtask

  int ph_inv[12]  = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
  int ph_log2[12] = '{3, 2, 0, 1, 4, 15, 10, 5, 6, 2, 7, 3};

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 0; in_ch.action = '0; in_ch.point_index = '0;
    in_ch.sample_re = '0; in_ch.sample_im = '0;
    out_ch.ready = 0;
    in_took = 0; out_took = 0; in_gap = 0; out_stall = 0;
    in_burst = 0; out_burst = 0;
    mode_inv = 0; mode_log2 = LOG2_RESET;
    for (int j = 0; j <= NPTS / 4; j++) sine_q15[j] = rom_entry(j);
    for (int i = 0; i < NPTS; i++) begin
      mem_re[i] = 0; mem_im[i] = 0; written[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes at size 4, ignored action, repeated runs to saturate
    write_cfg(CFG_LOG2, 4'd2);
    write_cfg(CFG_INVERSE, 1'b0);
    gen_n = 4;
    push_item(ACT_WRITE, 1023, 16'sh7fff, 16'sh8000);
    push_item(ACT_WRITE, 1022, 16'sh8000, 16'sh7fff);
    push_item(ACT_WRITE, 1021, 16'sh7fff, 16'sh7fff);
    push_item(ACT_WRITE, 0, 16'sh8000, 16'sh8000);
    push_item(ACT_NOP, 1, 16'sh1234, 16'sh4321);
    push_item(ACT_READ, 1023, 0, 0);
    push_item(ACT_RUN, 0, 0, 0);
    for (int i = 0; i < 4; i++) push_item(ACT_READ, alias_idx(i), 0, 0);
    repeat (10) push_item(ACT_RUN, 0, 0, 0);
    for (int i = 0; i < 4; i++) push_item(ACT_READ, i, 0, 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      if ($urandom_range(0, 1)) write_cfg(2'd3, 4'($urandom));
      else write_cfg(2'd2, 4'($urandom));
      write_cfg(CFG_INVERSE, ph_inv[p][0]);
      write_cfg(CFG_LOG2, ph_log2[p][3:0]);
      gen_n = 1 << eff_log2(ph_log2[p][3:0]);
      if (gen_n >= 128) begin
        fill_missing();
        push_item(ACT_RUN, 0, 0, 0);
        read_some(30);
      end else begin
        random_traffic(20);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
